### design/gastar_pkg.sv
`timescale 1ns / 1ps

package gastar_pkg;

    // Grid storage limits (coordinates are 6-bit fields)
    localparam int MAX_WIDTH      = 64;
    localparam int MAX_HEIGHT     = 64;
    localparam int COORD_W        = 6;
    localparam int GRID_REG_W     = 7;
    localparam int CELL_AW        = 12;
    localparam int NCELLS         = MAX_WIDTH * MAX_HEIGHT;
    localparam int COST_W         = 12;
    localparam int H_W            = 7;
    localparam int F_W            = 13;
    localparam int LIM_W          = 13;
    localparam int HEAP_DEPTH_DEF = 16384;

    // Request kinds (s_tuser)
    localparam logic REQ_WALL  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result codes (m_tuser)
    localparam logic [1:0] OUT_STEP     = 2'd0;
    localparam logic [1:0] OUT_NOPATH   = 2'd1;
    localparam logic [1:0] OUT_OVERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Neighbor directions in search order
    localparam logic [1:0] DIR_E = 2'd0;
    localparam logic [1:0] DIR_W = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_N = 2'd3;

    // Open-set key, ordered by (f, x, y)
    typedef struct packed {
        logic [F_W-1:0]     f;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } key_t;

    // Per-cell search record
    typedef struct packed {
        logic              known;
        logic              pvalid;
        logic [1:0]        dir;
        logic [COST_W-1:0] cost;
    } cell_t;

    // Heap unit command and status
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        key_t key;
    } heap_cmd_t;

    typedef struct packed {
        logic busy;
        logic full;
        logic empty;
        key_t top;
    } heap_stat_t;

    function automatic logic [COORD_W:0] step_dx(input logic [1:0] d);
        logic [COORD_W:0] r;
        case (d)
            DIR_E:   r = (COORD_W+1)'(1);
            DIR_W:   r = '1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W:0] step_dy(input logic [1:0] d);
        logic [COORD_W:0] r;
        case (d)
            DIR_S:   r = (COORD_W+1)'(1);
            DIR_N:   r = '1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [H_W-1:0] manhattan(input logic [COORD_W-1:0] ax,
                                                 input logic [COORD_W-1:0] ay,
                                                 input logic [COORD_W-1:0] bx,
                                                 input logic [COORD_W-1:0] by);
        return H_W'(absdiff(ax, bx)) + H_W'(absdiff(ay, by));
    endfunction

    function automatic logic in_grid(input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [GRID_REG_W-1:0] gw,
                                     input logic [GRID_REG_W-1:0] gh);
        return ({1'b0, x} < gw) && ({1'b0, y} < gh);
    endfunction

endpackage

### design/gastar_heap.sv
`timescale 1ns / 1ps

// Binary min-heap over a single-port-read memory, sifted one step at a time
module gastar_heap
    import gastar_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  heap_cmd_t  cmd,
    output heap_stat_t stat
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = AW + 1;

    typedef enum logic [7:0] {
        H_IDLE = 8'b00000001,
        H_UP   = 8'b00000010,
        H_UPW  = 8'b00000100,
        H_PT   = 8'b00001000,
        H_PL   = 8'b00010000,
        H_DN   = 8'b00100000,
        H_DC1  = 8'b01000000,
        H_DC2  = 8'b10000000
    } hstate_t;

    hstate_t       state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cidx_reg, cidx_next;
    key_t          key_reg, key_next;
    key_t          ch_reg, ch_next;
    key_t          top_reg, top_next;
    key_t          rd_data_reg;
    key_t          mem [HEAP_DEPTH];

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    key_t          wr_data;
    logic [AW:0]   child;
    logic [AW+1:0] child1;
    key_t          best;
    logic [AW-1:0] best_idx;

    // left child of the hole, and the right sibling of the child being read
    assign child  = {idx_reg, 1'b1};
    assign child1 = {2'b00, cidx_reg} + (AW+2)'(1);

    // Storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sift sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cidx_next  = cidx_reg;
        key_next   = key_reg;
        ch_next    = ch_reg;
        top_next   = top_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = key_reg;
        best       = rd_data_reg;
        best_idx   = cidx_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.clear)
                begin
                    cnt_next = '0;
                end
                else if (cmd.push)
                begin
                    idx_next   = cnt_reg[AW-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                    key_next   = cmd.key;
                    state_next = H_UP;
                end
                else if (cmd.pop)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = H_PT;
                end
            end
            H_UP:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    cidx_next  = (idx_reg - AW'(1)) >> 1;
                    rd_addr    = cidx_next;
                    state_next = H_UPW;
                end
            end
            H_UPW:
            begin
                wr_en = 1'b1;
                if (rd_data_reg <= key_reg)
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    wr_data    = rd_data_reg;
                    idx_next   = cidx_reg;
                    state_next = H_UP;
                end
            end
            H_PT:
            begin
                top_next = rd_data_reg;
                if (cnt_reg == '0)
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_addr    = cnt_reg[AW-1:0];
                    state_next = H_PL;
                end
            end
            H_PL:
            begin
                key_next   = rd_data_reg;
                idx_next   = '0;
                state_next = H_DN;
            end
            H_DN:
            begin
                if (child >= cnt_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    cidx_next  = child[AW-1:0];
                    rd_addr    = child[AW-1:0];
                    state_next = H_DC1;
                end
            end
            H_DC1, H_DC2:
            begin
                if (state_reg == H_DC1 && child1 < (AW+2)'(cnt_reg))
                begin
                    ch_next    = rd_data_reg;
                    rd_addr    = cidx_reg + AW'(1);
                    state_next = H_DC2;
                end
                else
                begin
                    // pick the smaller child, then compare against the moving key
                    if (state_reg == H_DC2)
                    begin
                        if (rd_data_reg < ch_reg)
                        begin
                            best     = rd_data_reg;
                            best_idx = cidx_reg + AW'(1);
                        end
                        else
                        begin
                            best = ch_reg;
                        end
                    end
                    wr_en = 1'b1;
                    if (key_reg <= best)
                    begin
                        state_next = H_IDLE;
                    end
                    else
                    begin
                        wr_data    = best;
                        idx_next   = best_idx;
                        state_next = H_DN;
                    end
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cidx_reg <= cidx_next;
        key_reg  <= key_next;
        ch_reg   <= ch_next;
        top_reg  <= top_next;
    end

    assign stat.busy  = (state_reg != H_IDLE);
    assign stat.full  = (cnt_reg >= CW'(HEAP_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign stat.top   = top_reg;

endmodule

### design/grid_astar_next_step_core.sv
`timescale 1ns / 1ps
// Map write: one wall cell per beat, taken while idle. Query: clear of all 4096 cell
// records, then neighbors tried with a heap push per open cell and a heap pop per
// expanded cell (one shared heap unit), then a traceback along the path; the heap
// holds at most HEAP_DEPTH keys. One query at a time; s_tready is low meanwhile.
// Reset (rst_n, async, active low) starts a pass over all 4096 cells that opens every
// wall map cell; s_tready stays low until it finishes. Config writes are taken anytime.
module grid_astar_next_step_core
    import gastar_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cell_x[5:0] cell_y[11:6] cell_blocked[12] from_x[18:13] from_y[24:19]
    // to_x[30:25] to_y[36:31], zero pad
    input  logic [39:0]           s_tdata,
    // req_type[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // step_x[5:0] step_y[11:6], zero pad
    output logic [15:0]           m_tdata,
    // outcome[1:0]
    output logic [1:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [GRID_REG_W-1:0] cfg_data
);

    typedef enum logic [10:0] {
        ST_CLR   = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_INIT  = 11'b00000000100,
        ST_POP   = 11'b00000001000,
        ST_POPW  = 11'b00000010000,
        ST_GC    = 11'b00000100000,
        ST_NB    = 11'b00001000000,
        ST_NBW   = 11'b00010000000,
        ST_PUSHW = 11'b00100000000,
        ST_TRW   = 11'b01000000000,
        ST_FIN   = 11'b10000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [GRID_REG_W-1:0]   grid_w_reg, grid_h_reg;
    logic [CELL_AW-1:0]      clr_reg, clr_next;
    logic                    wall_clr_reg, wall_clr_next;
    logic [COORD_W-1:0]      sx_reg, sy_reg, tx_reg, ty_reg;
    logic [COORD_W-1:0]      sx_next, sy_next, tx_next, ty_next;
    logic [COORD_W-1:0]      cx_reg, cy_reg, cx_next, cy_next;
    logic [COORD_W-1:0]      nx_reg, ny_reg, nx_next, ny_next;
    logic [H_W-1:0]          h_reg, h_next;
    logic [1:0]              dir_reg, dir_next;
    logic [COST_W-1:0]       gc_reg, gc_next;
    logic [LIM_W-1:0]        lim_reg, lim_next;
    logic [COORD_W-1:0]      res_x_reg, res_y_reg, res_x_next, res_y_next;
    logic [1:0]              res_code_reg, res_code_next;
    logic                    m_tvalid_reg;
    logic [15:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic                    wall_mem [NCELLS];
    cell_t                   cell_mem [NCELLS];
    logic                    wall_rd_reg;
    cell_t                   cell_rd_reg;
    logic                    wall_we, wall_wd, cell_we;
    logic [CELL_AW-1:0]      wall_wa, wall_ra, cell_wa, cell_ra;
    cell_t                   cell_wd;

    heap_cmd_t               hcmd;
    heap_stat_t              hstat;

    logic                    in_acc, can_load;
    logic [COORD_W:0]        nx7, ny7, px7, py7;
    logic [COST_W-1:0]       ng;
    logic                    t_ok;

    gastar_heap #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hcmd),
        .stat  (hstat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign can_load  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign ng        = gc_reg + COST_W'(1);
    assign t_ok      = in_grid(tx_reg, ty_reg, grid_w_reg, grid_h_reg);

    // Wall map and cell records, registered reads
    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_wa] <= wall_wd;
        end
        if (cell_we)
        begin
            cell_mem[cell_wa] <= cell_wd;
        end
        wall_rd_reg <= wall_mem[wall_ra];
        cell_rd_reg <= cell_mem[cell_ra];
    end

    // Search sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        wall_clr_next = wall_clr_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        h_next        = h_reg;
        dir_next      = dir_reg;
        gc_next       = gc_reg;
        lim_next      = lim_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_code_next = res_code_reg;
        hcmd          = '0;
        wall_we       = 1'b0;
        wall_wd       = 1'b0;
        wall_wa       = clr_reg;
        wall_ra       = '0;
        cell_we       = 1'b0;
        cell_wd       = '0;
        cell_wa       = clr_reg;
        cell_ra       = '0;
        nx7           = {1'b0, cx_reg} + step_dx(dir_reg);
        ny7           = {1'b0, cy_reg} + step_dy(dir_reg);
        px7           = {1'b0, cx_reg} - step_dx(cell_rd_reg.dir);
        py7           = {1'b0, cy_reg} - step_dy(cell_rd_reg.dir);
        unique case (state_reg)
            ST_CLR:
            begin
                cell_we  = 1'b1;
                wall_we  = wall_clr_reg;
                clr_next = clr_reg + CELL_AW'(1);
                if (clr_reg == '1)
                begin
                    wall_clr_next = 1'b0;
                    state_next    = wall_clr_reg ? ST_IDLE : ST_INIT;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == REQ_WALL)
                    begin
                        wall_we = 1'b1;
                        wall_wa = {s_tdata[11:6], s_tdata[5:0]};
                        wall_wd = s_tdata[12];
                    end
                    else
                    begin
                        sx_next    = s_tdata[18:13];
                        sy_next    = s_tdata[24:19];
                        tx_next    = s_tdata[30:25];
                        ty_next    = s_tdata[36:31];
                        clr_next   = '0;
                        hcmd.clear = 1'b1;
                        state_next = ST_CLR;
                    end
                end
            end
            ST_INIT:
            begin
                cell_wa       = {sy_reg, sx_reg};
                cell_wd.known = 1'b1;
                cell_we       = in_grid(sx_reg, sy_reg, grid_w_reg, grid_h_reg);
                hcmd.push     = 1'b1;
                hcmd.key.f    = F_W'(manhattan(sx_reg, sy_reg, tx_reg, ty_reg));
                hcmd.key.x    = sx_reg;
                hcmd.key.y    = sy_reg;
                state_next    = ST_POP;
            end
            ST_POP:
            begin
                if (!hstat.busy)
                begin
                    if (hstat.empty)
                    begin
                        // heap drained: walk back from the target
                        cx_next  = tx_reg;
                        cy_next  = ty_reg;
                        lim_next = '0;
                        cell_ra  = {ty_reg, tx_reg};
                        if (t_ok)
                        begin
                            state_next = ST_TRW;
                        end
                        else
                        begin
                            res_x_next    = sx_reg;
                            res_y_next    = sy_reg;
                            res_code_next = OUT_NOPATH;
                            state_next    = ST_FIN;
                        end
                    end
                    else
                    begin
                        hcmd.pop   = 1'b1;
                        state_next = ST_POPW;
                    end
                end
            end
            ST_POPW:
            begin
                if (!hstat.busy)
                begin
                    cx_next  = hstat.top.x;
                    cy_next  = hstat.top.y;
                    dir_next = DIR_E;
                    if (hstat.top.x == tx_reg && hstat.top.y == ty_reg)
                    begin
                        // target popped: walk back from it
                        lim_next = '0;
                        cell_ra  = {ty_reg, tx_reg};
                        if (t_ok)
                        begin
                            state_next = ST_TRW;
                        end
                        else
                        begin
                            res_x_next    = sx_reg;
                            res_y_next    = sy_reg;
                            res_code_next = OUT_NOPATH;
                            state_next    = ST_FIN;
                        end
                    end
                    else if (hstat.top.x == sx_reg && hstat.top.y == sy_reg)
                    begin
                        gc_next    = '0;
                        state_next = ST_NB;
                    end
                    else if (in_grid(hstat.top.x, hstat.top.y, grid_w_reg, grid_h_reg))
                    begin
                        cell_ra    = {hstat.top.y, hstat.top.x};
                        state_next = ST_GC;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_GC:
            begin
                gc_next    = cell_rd_reg.cost;
                state_next = ST_NB;
            end
            ST_NB:
            begin
                if (nx7[COORD_W] || ny7[COORD_W] ||
                    !in_grid(nx7[COORD_W-1:0], ny7[COORD_W-1:0], grid_w_reg, grid_h_reg))
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = (dir_reg == DIR_N) ? ST_POP : ST_NB;
                end
                else
                begin
                    nx_next    = nx7[COORD_W-1:0];
                    ny_next    = ny7[COORD_W-1:0];
                    h_next     = manhattan(nx7[COORD_W-1:0], ny7[COORD_W-1:0],
                                           tx_reg, ty_reg);
                    cell_ra    = {ny7[COORD_W-1:0], nx7[COORD_W-1:0]};
                    wall_ra    = {ny7[COORD_W-1:0], nx7[COORD_W-1:0]};
                    state_next = ST_NBW;
                end
            end
            ST_NBW:
            begin
                if (!wall_rd_reg && (!cell_rd_reg.known || ng < cell_rd_reg.cost))
                begin
                    if (hstat.full)
                    begin
                        res_x_next    = sx_reg;
                        res_y_next    = sy_reg;
                        res_code_next = OUT_OVERFLOW;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        hcmd.push      = 1'b1;
                        hcmd.key.f     = F_W'(ng) + F_W'(h_reg);
                        hcmd.key.x     = nx_reg;
                        hcmd.key.y     = ny_reg;
                        cell_we        = 1'b1;
                        cell_wa        = {ny_reg, nx_reg};
                        cell_wd.known  = 1'b1;
                        cell_wd.pvalid = 1'b1;
                        cell_wd.dir    = dir_reg;
                        cell_wd.cost   = ng;
                        state_next     = ST_PUSHW;
                    end
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = (dir_reg == DIR_N) ? ST_POP : ST_NB;
                end
            end
            ST_PUSHW:
            begin
                if (!hstat.busy)
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = (dir_reg == DIR_N) ? ST_POP : ST_NB;
                end
            end
            ST_TRW:
            begin
                // cx/cy hold the cell whose record is in cell_rd_reg
                res_x_next    = sx_reg;
                res_y_next    = sy_reg;
                res_code_next = OUT_NOPATH;
                if (!cell_rd_reg.pvalid)
                begin
                    state_next = ST_FIN;
                end
                else if (px7[COORD_W-1:0] == sx_reg && py7[COORD_W-1:0] == sy_reg)
                begin
                    res_x_next    = cx_reg;
                    res_y_next    = cy_reg;
                    res_code_next = OUT_STEP;
                    state_next    = ST_FIN;
                end
                else if (lim_reg == LIM_W'(NCELLS) ||
                         !in_grid(px7[COORD_W-1:0], py7[COORD_W-1:0],
                                  grid_w_reg, grid_h_reg))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    lim_next = lim_reg + LIM_W'(1);
                    cx_next  = px7[COORD_W-1:0];
                    cy_next  = py7[COORD_W-1:0];
                    cell_ra  = {py7[COORD_W-1:0], px7[COORD_W-1:0]};
                end
            end
            ST_FIN:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            clr_reg      <= '0;
            wall_clr_reg <= 1'b1;
            grid_w_reg   <= GRID_REG_W'(MAX_WIDTH);
            grid_h_reg   <= GRID_REG_W'(MAX_HEIGHT);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            wall_clr_reg <= wall_clr_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  grid_w_reg <= cfg_data;
                    CFG_HEIGHT: grid_h_reg <= cfg_data;
                    default:    grid_w_reg <= grid_w_reg;
                endcase
            end
            if (state_reg == ST_FIN && can_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        h_reg        <= h_next;
        dir_reg      <= dir_next;
        gc_reg       <= gc_next;
        lim_reg      <= lim_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_code_reg <= res_code_next;
        if (state_reg == ST_FIN && can_load)
        begin
            m_tdata_reg <= {4'd0, res_y_reg, res_x_reg};
            m_tuser_reg <= res_code_reg;
        end
    end

    // Checks
    a_heap_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(hstat.full && hstat.empty))
        else $error("heap reports full and empty together");

    a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == OUT_STEP || m_tuser == OUT_NOPATH ||
                      m_tuser == OUT_OVERFLOW))
        else $error("result carries an unused outcome code");

    a_step_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && can_load && res_code_reg == OUT_STEP) |->
            (manhattan(res_x_reg, res_y_reg, sx_reg, sy_reg) == H_W'(1)))
        else $error("reported step is not next to the start cell");

    a_stay_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && can_load && res_code_reg != OUT_STEP) |->
            (res_x_reg == sx_reg && res_y_reg == sy_reg))
        else $error("stay result does not hold the start cell");

endmodule
